// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the run-length coder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// File: design/rbc_pkg.sv
// ----------------------------------------------------------------------------
// Run-length coder package
// Constants, command format and status groups shared by the coder modules.
// ----------------------------------------------------------------------------
package rbc_pkg;

  // Longest literal segment and the store that holds it (two banks).
  localparam int LIT_MAX   = 128;
  localparam int LIT_IDX_W = $clog2(LIT_MAX);
  localparam int RAM_DEPTH = 2 * LIT_MAX;
  localparam int RAM_AW    = LIT_IDX_W + 1;

  // Width of the minimum repeat length register and its value after reset.
  localparam int          MIN_W            = 5;
  localparam logic [4:0]  REPEAT_MIN_RESET = 5'd3;

  // Literal count bytes carry length plus this bias; runs cap at min plus it.
  localparam logic [7:0]  LIT_BIAS = 8'd127;
  localparam logic [8:0]  CAP_BIAS = 9'd127;

  // Depth of the command queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic {
    CMD_REPEAT,
    CMD_LITERAL
  } cmd_kind_e;

  // One segment to be coded by the back end.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  code;       // count byte
    logic [7:0]  value;      // repeated byte
    logic [7:0]  lit_len;    // literal length, 1 to 128
    logic        bank;       // store bank holding the literal bytes
    logic        frame_end;
    logic [31:0] frame_len;
  } cmd_t;

  // Back end hands a store bank back to the front.
  typedef struct packed {
    logic done;
    logic bank;
  } bank_rel_t;

  // Store write request from the front.
  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

endpackage

// File: design/rbc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module rbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/rbc_front.sv
// ----------------------------------------------------------------------------
// Run-length coder front end
// Accepts bytes, tracks runs and literal segments, fills the literal store
// and issues segment commands to the back end.
// ----------------------------------------------------------------------------
module rbc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 frame_last_i,
  input  logic [4:0]           repeat_min_i,
  output logic                 full_o,
  output rbc_pkg::cmd_t        cmd_o,
  output logic                 cmd_push_o,
  input  logic                 q_full_i,
  input  rbc_pkg::bank_rel_t   rel_i,
  output rbc_pkg::store_wr_t   wr_o
);
  import rbc_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_STEP = 2'd1;
  localparam logic [1:0] F_FILL = 2'd2;
  localparam logic [1:0] F_LAST = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic [7:0]       run_val_q, run_val_d;
  logic [7:0]       run_len_q, run_len_d;
  logic             lit_q, lit_d;
  logic [7:0]       seg_q, seg_d;
  logic [31:0]      cc_q, cc_d;
  logic [MIN_W-1:0] amin_q, amin_d;
  logic             open_q, open_d;
  logic             bank_q, bank_d;
  logic [1:0]       busy_q, busy_d;
  logic [MIN_W-1:0] fill_idx_q, fill_idx_d;
  logic             fill_last_q, fill_last_d;

  logic             accept;
  logic [1:0]       nxt;
  logic [7:0]       min8;
  logic             eq;
  logic [8:0]       len1;
  logic [7:0]       rl;
  logic             cmd_push;
  logic             go_idle;
  cmd_kind_e        push_kind;
  logic [7:0]       push_len;
  logic [7:0]       push_code;
  logic [7:0]       push_val;
  logic             push_end;
  logic [31:0]      add;
  logic [31:0]      flen;

  assign full_o = (state_q != F_IDLE);
  assign accept = push_i && !full_o;
  assign nxt    = last_q ? F_LAST : F_IDLE;
  assign min8   = {3'b000, amin_q};
  assign eq     = (byte_q == run_val_q);
  assign len1   = {1'b0, run_len_q} + 9'd1;
  assign rl     = eq ? (run_len_q + 8'd1) : 8'd1;

  // Sequencer: classify the held byte and drive pushes and store writes.
  always_comb begin
    state_d     = state_q;
    byte_d      = byte_q;
    last_d      = last_q;
    run_val_d   = run_val_q;
    run_len_d   = run_len_q;
    lit_d       = lit_q;
    seg_d       = seg_q;
    cc_d        = cc_q;
    amin_d      = amin_q;
    open_d      = open_q;
    bank_d      = bank_q;
    busy_d      = busy_q;
    fill_idx_d  = fill_idx_q;
    fill_last_d = fill_last_q;
    cmd_push    = 1'b0;
    go_idle     = 1'b0;
    push_kind   = CMD_REPEAT;
    push_len    = '0;
    push_code   = '0;
    push_val    = '0;
    push_end    = 1'b0;
    wr_o        = '0;

    // A bank whose literal has been sent out is free again.
    if (rel_i.done) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    case (state_q)
      F_IDLE: begin
        if (accept) begin
          byte_d  = data_byte_i;
          last_d  = frame_last_i;
          state_d = F_STEP;
          if (!open_q) begin
            amin_d = repeat_min_i;
            open_d = 1'b1;
          end
        end
      end

      F_STEP: begin
        if (!lit_q) begin
          if (run_len_q == 8'd0) begin
            run_val_d = byte_q;
            run_len_d = 8'd1;
            state_d   = nxt;
          end else if (eq) begin
            // Extend the run; at the cap the run is sent and restarted.
            if (len1 >= ({4'b0000, amin_q} + CAP_BIAS)) begin
              if (!q_full_i) begin
                cmd_push  = 1'b1;
                push_code = len1[7:0] - min8;
                push_val  = run_val_q;
                push_end  = last_q;
                run_len_d = 8'd0;
                state_d   = nxt;
              end
            end else begin
              run_len_d = len1[7:0];
              state_d   = nxt;
            end
          end else if (run_len_q >= min8) begin
            if (!q_full_i) begin
              cmd_push  = 1'b1;
              push_code = run_len_q - min8;
              push_val  = run_val_q;
              run_val_d = byte_q;
              run_len_d = 8'd1;
              state_d   = nxt;
            end
          end else if (!busy_q[bank_q]) begin
            // Short run broken: it opens a literal segment.
            fill_idx_d  = '0;
            fill_last_d = 1'b0;
            state_d     = F_FILL;
          end
        end else begin
          if (rl >= min8) begin
            // A run reaching the minimum closes the literal before it.
            if (!q_full_i) begin
              cmd_push  = 1'b1;
              push_kind = CMD_LITERAL;
              push_len  = seg_q - (eq ? run_len_q : 8'd0);
              lit_d     = 1'b0;
              seg_d     = 8'd0;
              run_val_d = byte_q;
              run_len_d = rl;
              state_d   = nxt;
            end
          end else if (seg_q >= 8'(LIT_MAX)) begin
            if (!q_full_i) begin
              cmd_push  = 1'b1;
              push_kind = CMD_LITERAL;
              push_len  = seg_q;
              lit_d     = 1'b0;
              seg_d     = 8'd0;
              run_val_d = byte_q;
              run_len_d = 8'd1;
              state_d   = nxt;
            end
          end else begin
            wr_o.we   = 1'b1;
            wr_o.addr = {bank_q, seg_q[LIT_IDX_W-1:0]};
            wr_o.data = byte_q;
            seg_d     = seg_q + 8'd1;
            run_val_d = byte_q;
            run_len_d = rl;
            state_d   = nxt;
          end
        end
      end

      F_FILL: begin
        if ({3'b000, fill_idx_q} < run_len_q) begin
          // Copy the run value into the store, one entry a cycle.
          wr_o.we    = 1'b1;
          wr_o.addr  = {bank_q, LIT_IDX_W'(fill_idx_q)};
          wr_o.data  = run_val_q;
          fill_idx_d = fill_idx_q + 5'd1;
        end else if (!fill_last_q) begin
          wr_o.we   = 1'b1;
          wr_o.addr = {bank_q, run_len_q[LIT_IDX_W-1:0]};
          wr_o.data = byte_q;
          seg_d     = run_len_q + 8'd1;
          lit_d     = 1'b1;
          run_val_d = byte_q;
          run_len_d = 8'd1;
          state_d   = nxt;
        end else if (!q_full_i) begin
          cmd_push  = 1'b1;
          push_kind = CMD_LITERAL;
          push_len  = run_len_q;
          push_end  = 1'b1;
          go_idle   = 1'b1;
        end
      end

      F_LAST: begin
        // Close whatever segment is still open at frame end.
        if (lit_q) begin
          if (!q_full_i) begin
            cmd_push  = 1'b1;
            push_kind = CMD_LITERAL;
            push_len  = seg_q;
            push_end  = 1'b1;
            go_idle   = 1'b1;
          end
        end else if (run_len_q == 8'd0) begin
          go_idle = 1'b1;
        end else if (run_len_q >= min8) begin
          if (!q_full_i) begin
            cmd_push  = 1'b1;
            push_code = run_len_q - min8;
            push_val  = run_val_q;
            push_end  = 1'b1;
            go_idle   = 1'b1;
          end
        end else if (!busy_q[bank_q]) begin
          fill_idx_d  = '0;
          fill_last_d = 1'b1;
          state_d     = F_FILL;
        end
      end

      default: begin
        state_d = F_IDLE;
      end
    endcase

    // Running code length; a literal hands its bank over and swaps banks.
    add  = (push_kind == CMD_LITERAL) ? ({24'd0, push_len} + 32'd1) : 32'd2;
    flen = cc_q + add;
    if (cmd_push) begin
      cc_d = flen;
      if (push_kind == CMD_LITERAL) begin
        busy_d[bank_q] = 1'b1;
        bank_d         = ~bank_q;
      end
    end

    if (go_idle) begin
      run_val_d = '0;
      run_len_d = '0;
      lit_d     = 1'b0;
      seg_d     = '0;
      cc_d      = '0;
      open_d    = 1'b0;
      state_d   = F_IDLE;
    end
  end

  // Command to the queue.
  always_comb begin
    cmd_o.kind      = push_kind;
    cmd_o.code      = (push_kind == CMD_LITERAL) ? (push_len + LIT_BIAS) : push_code;
    cmd_o.value     = push_val;
    cmd_o.lit_len   = push_len;
    cmd_o.bank      = bank_q;
    cmd_o.frame_end = push_end;
    cmd_o.frame_len = push_end ? flen : 32'd0;
  end

  assign cmd_push_o = cmd_push;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      run_val_q   <= '0;
      run_len_q   <= '0;
      lit_q       <= 1'b0;
      seg_q       <= '0;
      cc_q        <= '0;
      amin_q      <= REPEAT_MIN_RESET;
      open_q      <= 1'b0;
      bank_q      <= 1'b0;
      busy_q      <= '0;
      fill_idx_q  <= '0;
      fill_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_val_q   <= run_val_d;
      run_len_q   <= run_len_d;
      lit_q       <= lit_d;
      seg_q       <= seg_d;
      cc_q        <= cc_d;
      amin_q      <= amin_d;
      open_q      <= open_d;
      bank_q      <= bank_d;
      busy_q      <= busy_d;
      fill_idx_q  <= fill_idx_d;
      fill_last_q <= fill_last_d;
    end
  end

  // Held input byte.
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

endmodule

// File: design/rbc_cmd_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out queue of segment commands from front to back.
// ----------------------------------------------------------------------------
module rbc_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rbc_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output rbc_pkg::cmd_t cmd_o,
  output logic          empty_o
);
  import rbc_pkg::*;

  cmd_t              ent_q [QDEPTH];
  logic [QPTR_W-1:0] wp_q, rp_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (QPTR_W + 1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = ent_q[rp_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= rp_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entries.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wp_q] <= cmd_i;
    end
  end

endmodule

// File: design/rbc_back.sv
// ----------------------------------------------------------------------------
// Run-length coder back end
// Turns segment commands into results of up to four code bytes, reading
// literal bytes from the store, and holds each result until it is taken.
// ----------------------------------------------------------------------------
module rbc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rbc_pkg::cmd_t                cmd_i,
  input  logic                         q_empty_i,
  output logic                         q_pop_o,
  output logic                         rd_en_o,
  output logic [rbc_pkg::RAM_AW-1:0]   rd_addr_o,
  input  logic [7:0]                   rd_data_i,
  output rbc_pkg::bank_rel_t           rel_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic [7:0]                   out_byte0_o,
  output logic [7:0]                   out_byte1_o,
  output logic [7:0]                   out_byte2_o,
  output logic [7:0]                   out_byte3_o,
  output logic [2:0]                   byte_count_o,
  output logic                         frame_end_o,
  output logic [31:0]                  frame_length_o
);
  import rbc_pkg::*;

  logic                 busy_q;
  logic [3:0][7:0]      word_q;
  logic [1:0]           pos_q;
  logic [7:0]           rd_rem_q;
  logic [7:0]           cap_rem_q;
  logic [LIT_IDX_W-1:0] rd_idx_q;
  logic                 bank_q;
  logic                 pend_q;
  logic                 end_q;
  logic [31:0]          flen_q;

  logic                 out_valid_q;
  logic [3:0][7:0]      out_q;
  logic [2:0]           cnt_q;
  logic                 oend_q;
  logic [31:0]          olen_q;

  logic                 out_free;
  logic                 full_word;
  logic                 capture;
  logic                 take;
  logic                 load_word;
  logic [3:0][7:0]      word_out;

  assign out_free  = !out_valid_q || pop_i;
  assign full_word = (pos_q == 2'd3) || (cap_rem_q == 8'd1);
  assign capture   = pend_q && (!full_word || out_free);
  assign load_word = capture && full_word;
  assign take      = !busy_q && !q_empty_i && ((cmd_i.kind == CMD_LITERAL) || out_free);
  assign q_pop_o   = take;

  // Store read: one entry a cycle while the captured data can move on.
  assign rd_en_o   = busy_q && (rd_rem_q != 8'd0) && (!pend_q || capture);
  assign rd_addr_o = {bank_q, rd_idx_q};

  assign rel_o.done = capture && (cap_rem_q == 8'd1);
  assign rel_o.bank = bank_q;

  // Result word: bytes gathered so far, the new byte, zeros beyond.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (2'(i) < pos_q) begin
        word_out[i] = word_q[i];
      end else if (2'(i) == pos_q) begin
        word_out[i] = rd_data_i;
      end else begin
        word_out[i] = 8'd0;
      end
    end
  end

  // Literal assembly control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      pend_q    <= 1'b0;
      pos_q     <= '0;
      rd_rem_q  <= '0;
      cap_rem_q <= '0;
      rd_idx_q  <= '0;
    end else begin
      if (take && (cmd_i.kind == CMD_LITERAL)) begin
        busy_q    <= 1'b1;
        pos_q     <= 2'd1;
        rd_rem_q  <= cmd_i.lit_len;
        cap_rem_q <= cmd_i.lit_len;
        rd_idx_q  <= '0;
      end
      if (rd_en_o) begin
        rd_idx_q <= rd_idx_q + 1'b1;
        rd_rem_q <= rd_rem_q - 8'd1;
      end
      pend_q <= rd_en_o || (pend_q && !capture);
      if (capture) begin
        cap_rem_q <= cap_rem_q - 8'd1;
        pos_q     <= full_word ? 2'd0 : (pos_q + 2'd1);
        if (cap_rem_q == 8'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Literal payload held during assembly.
  always_ff @(posedge clk_i) begin
    if (take && (cmd_i.kind == CMD_LITERAL)) begin
      word_q[0] <= cmd_i.code;
      bank_q    <= cmd_i.bank;
      end_q     <= cmd_i.frame_end;
      flen_q    <= cmd_i.frame_len;
    end else if (capture && !full_word) begin
      word_q[pos_q] <= rd_data_i;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_word || (take && (cmd_i.kind == CMD_REPEAT))) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (take && (cmd_i.kind == CMD_REPEAT)) begin
      out_q  <= {8'd0, 8'd0, cmd_i.value, cmd_i.code};
      cnt_q  <= 3'd2;
      oend_q <= cmd_i.frame_end;
      olen_q <= cmd_i.frame_len;
    end else if (load_word) begin
      out_q  <= word_out;
      cnt_q  <= {1'b0, pos_q} + 3'd1;
      oend_q <= end_q && (cap_rem_q == 8'd1);
      olen_q <= (end_q && (cap_rem_q == 8'd1)) ? flen_q : 32'd0;
    end
  end

  assign empty_o        = !out_valid_q;
  assign out_byte0_o    = out_q[0];
  assign out_byte1_o    = out_q[1];
  assign out_byte2_o    = out_q[2];
  assign out_byte3_o    = out_q[3];
  assign byte_count_o   = cnt_q;
  assign frame_end_o    = oend_q;
  assign frame_length_o = olen_q;

endmodule

// File: design/rle_byte_compressor.sv
// ----------------------------------------------------------------------------
// Run-length byte compressor
// Run-length coder: raw frame bytes in, results of up to four code
// bytes out, frame code length given on the frame's final result.
// ----------------------------------------------------------------------------
// The front end accepts each byte, then classifies it; a frame's last
// byte then passes through a closing step for the open segment. When a
// short run turns into a literal segment, the front end copies that run
// into the literal store and then writes the byte that broke it; a short
// trailing run at frame end is copied and then sent. A full command queue
// holds the front end until the back end takes a command. The back end
// reads literal bytes through the store's single read port at one byte a
// cycle while its result register can take them. The store has two banks
// of 128 bytes; a new literal segment waits while its bank still holds a
// literal that has not been sent out. The minimum run length is sampled at
// a frame's first byte and holds until the frame ends.
// ----------------------------------------------------------------------------
module rle_byte_compressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_last_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte0_o,
  output logic [7:0]  out_byte1_o,
  output logic [7:0]  out_byte2_o,
  output logic [7:0]  out_byte3_o,
  output logic [2:0]  byte_count_o,
  output logic        frame_end_o,
  output logic [31:0] frame_length_o
);
  import rbc_pkg::*;

  logic [MIN_W-1:0] repeat_min_q;
  cmd_t             fe_cmd;
  logic             fe_push;
  logic             q_full;
  cmd_t             q_cmd;
  logic             q_empty;
  logic             q_pop;
  bank_rel_t        rel;
  store_wr_t        wr;
  logic             rd_en;
  logic [RAM_AW-1:0] rd_addr;
  logic [7:0]       rd_data;

  // Minimum repeat length register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_min_q <= REPEAT_MIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      repeat_min_q <= cfg_data_i;
    end
  end

  // Front end: classification and store fill.
  rbc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .data_byte_i  (data_byte_i),
    .frame_last_i (frame_last_i),
    .repeat_min_i (repeat_min_q),
    .full_o       (full),
    .cmd_o        (fe_cmd),
    .cmd_push_o   (fe_push),
    .q_full_i     (q_full),
    .rel_i        (rel),
    .wr_o         (wr)
  );

  // Segment commands between the two halves.
  rbc_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .cmd_i   (fe_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd),
    .empty_o (q_empty)
  );

  // Literal store, two banks.
  rbc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Back end: result packing and output register.
  rbc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (q_cmd),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .rel_o          (rel),
    .pop_i          (pop),
    .empty_o        (empty),
    .out_byte0_o    (out_byte0_o),
    .out_byte1_o    (out_byte1_o),
    .out_byte2_o    (out_byte2_o),
    .out_byte3_o    (out_byte3_o),
    .byte_count_o   (byte_count_o),
    .frame_end_o    (frame_end_o),
    .frame_length_o (frame_length_o)
  );

endmodule

// File: design/rbc_checker.sv
// ----------------------------------------------------------------------------
// Run-length coder checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_byte0_o,
  input logic [7:0]  out_byte1_o,
  input logic [7:0]  out_byte2_o,
  input logic [7:0]  out_byte3_o,
  input logic [2:0]  byte_count_o,
  input logic        frame_end_o,
  input logic [31:0] frame_length_o
);

  logic count_ok;
  logic pad_zero;

  // Count range and zero bytes beyond the count.
  assign count_ok = (byte_count_o >= 3'd1) && (byte_count_o <= 3'd4);
  assign pad_zero = (byte_count_o > 3'd3 || out_byte3_o == 8'd0) &&
                    (byte_count_o > 3'd2 || out_byte2_o == 8'd0) &&
                    (byte_count_o > 3'd1 || out_byte1_o == 8'd0);

  // A waiting result stays valid, with its first byte unchanged, until it is taken.
  `RBC_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_byte0_o), "result not held")

  // Every result carries one to four code bytes.
  `RBC_ASSERT_NOW(a_count, !empty, count_ok, "byte count out of range")

  // Bytes beyond the count are zero.
  `RBC_ASSERT_NOW(a_pad, !empty, pad_zero, "padding bytes not zero")

  // Frame length shows only on a frame's final result.
  `RBC_ASSERT_NOW(a_len, !empty && !frame_end_o, frame_length_o == 32'd0, "stray frame length")

endmodule

bind rle_byte_compressor rbc_checker u_rbc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .out_byte0_o    (out_byte0_o),
  .out_byte1_o    (out_byte1_o),
  .out_byte2_o    (out_byte2_o),
  .out_byte3_o    (out_byte3_o),
  .byte_count_o   (byte_count_o),
  .frame_end_o    (frame_end_o),
  .frame_length_o (frame_length_o)
);
